// ===== rtl/multimeter_packet_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// multimeter packet decoder assertion macros
// concurrent checks on clk, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef MULTIMETER_PACKET_DECODER_ASSERT_SVH
`define MULTIMETER_PACKET_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// check that holds only outside reset
`define MPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds through reset
`define MPD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MPD_ASSERT(lbl, prop, msg)
`define MPD_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== rtl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg
// types, codes and range tables of the multimeter packet decoder
// ----------------------------------------------------------------------------
package mpd_pkg;

  // measurement modes
  typedef enum logic [3:0] {
    MODE_VOLT    = 4'd0,
    MODE_CURRENT = 4'd1,
    MODE_OHM     = 4'd2,
    MODE_CONT    = 4'd3,
    MODE_DIODE   = 4'd4,
    MODE_FREQ    = 4'd5,
    MODE_CAP     = 4'd6,
    MODE_TEMP    = 4'd7,
    MODE_ADP     = 4'd8,
    MODE_DUTY    = 4'd9,
    MODE_UNKNOWN = 4'd10
  } mode_t;

  // unit prefixes
  typedef enum logic [2:0] {
    PFX_ZERO  = 3'd0,
    PFX_NANO  = 3'd1,
    PFX_MICRO = 3'd2,
    PFX_MILLI = 3'd3,
    PFX_UNIT  = 3'd4,
    PFX_KILO  = 3'd5,
    PFX_MEGA  = 3'd6
  } prefix_t;

  typedef enum logic [1:0] {
    OP_NORMAL    = 2'd0,
    OP_UNDERLOAD = 2'd1,
    OP_OVERLOAD  = 2'd2
  } oper_t;

  typedef enum logic [1:0] {
    CPL_NONE = 2'd0,
    CPL_DC   = 2'd1,
    CPL_AC   = 2'd2
  } cpl_t;

  typedef enum logic [1:0] {
    PEAK_NONE = 2'd0,
    PEAK_MAX  = 2'd1,
    PEAK_MIN  = 2'd2
  } peak_t;

  // dial bytes
  localparam logic [7:0] FN_VOLT     = 8'h3B;
  localparam logic [7:0] FN_AUTO_UA  = 8'h3D;
  localparam logic [7:0] FN_AUTO_MA  = 8'h3F;
  localparam logic [7:0] FN_22A      = 8'h30;
  localparam logic [7:0] FN_MANUAL_A = 8'h39;
  localparam logic [7:0] FN_OHM      = 8'h33;
  localparam logic [7:0] FN_CONT     = 8'h35;
  localparam logic [7:0] FN_DIODE    = 8'h31;
  localparam logic [7:0] FN_FREQ     = 8'h32;
  localparam logic [7:0] FN_CAP      = 8'h36;
  localparam logic [7:0] FN_TEMP     = 8'h34;
  localparam logic [7:0] FN_ADP      = 8'h3E;

  // ascii digit and range byte windows
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [7:0] RANGE_LO = 8'h30;
  localparam logic [7:0] RANGE_HI = 8'h37;

  localparam int DIAL_COUNT  = 12;
  localparam int RANGE_COUNT = 8;
  localparam int DIAL_IDX_W  = $clog2(DIAL_COUNT);
  localparam int RANGE_IDX_W = $clog2(RANGE_COUNT);

  // dial table rows
  localparam logic [DIAL_IDX_W-1:0] DIAL_VOLT     = DIAL_IDX_W'(0);
  localparam logic [DIAL_IDX_W-1:0] DIAL_AUTO_UA  = DIAL_IDX_W'(1);
  localparam logic [DIAL_IDX_W-1:0] DIAL_AUTO_MA  = DIAL_IDX_W'(2);
  localparam logic [DIAL_IDX_W-1:0] DIAL_22A      = DIAL_IDX_W'(3);
  localparam logic [DIAL_IDX_W-1:0] DIAL_MANUAL_A = DIAL_IDX_W'(4);
  localparam logic [DIAL_IDX_W-1:0] DIAL_OHM      = DIAL_IDX_W'(5);
  localparam logic [DIAL_IDX_W-1:0] DIAL_CONT     = DIAL_IDX_W'(6);
  localparam logic [DIAL_IDX_W-1:0] DIAL_DIODE    = DIAL_IDX_W'(7);
  localparam logic [DIAL_IDX_W-1:0] DIAL_FREQ     = DIAL_IDX_W'(8);
  localparam logic [DIAL_IDX_W-1:0] DIAL_CAP      = DIAL_IDX_W'(9);
  localparam logic [DIAL_IDX_W-1:0] DIAL_TEMP     = DIAL_IDX_W'(10);
  localparam logic [DIAL_IDX_W-1:0] DIAL_ADP      = DIAL_IDX_W'(11);

  typedef struct packed {
    logic [7:0] range_code;
    logic [7:0] digit_ten_thousands;
    logic [7:0] digit_thousands;
    logic [7:0] digit_hundreds;
    logic [7:0] digit_tens;
    logic [7:0] digit_units;
    logic [7:0] function_code;
    logic [7:0] status_byte;
    logic [7:0] option_one;
    logic [7:0] option_two;
    logic [7:0] option_three;
    logic [7:0] option_four;
  } mpd_in_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [2:0]  point_position;
    logic [2:0]  unit_prefix;
    logic [16:0] magnitude;
    logic        negative;
    logic [1:0]  operation;
    logic [1:0]  coupling;
    logic        auto_range;
    logic        batt_low;
    logic        relative_mode;
    logic        hold_mode;
    logic [1:0]  peak_mode;
  } mpd_out_t;

  typedef struct packed {
    logic                  valid;
    prefix_t               prefix;
    logic [2:0]            point;
  } range_ent_t;

  typedef struct packed {
    logic                  hit;
    mode_t                 mode;
    logic [DIAL_IDX_W-1:0] row;
  } dial_t;

  function automatic range_ent_t mk_rng(prefix_t p, logic [2:0] d);
    range_ent_t e;
    e.valid  = 1'b1;
    e.prefix = p;
    e.point  = d;
    return e;
  endfunction

  localparam range_ent_t RNG_NONE = '0;

  localparam range_ent_t RANGE_TBL [0:DIAL_COUNT-1][0:RANGE_COUNT-1] = '{
    '{mk_rng(PFX_UNIT, 3'd4), mk_rng(PFX_UNIT, 3'd3), mk_rng(PFX_UNIT, 3'd2),
      mk_rng(PFX_UNIT, 3'd1), mk_rng(PFX_MILLI, 3'd2), RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_MICRO, 3'd2), mk_rng(PFX_MICRO, 3'd1), RNG_NONE, RNG_NONE,
      RNG_NONE, RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_MILLI, 3'd3), mk_rng(PFX_MILLI, 3'd2), RNG_NONE, RNG_NONE,
      RNG_NONE, RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_UNIT, 3'd3), RNG_NONE, RNG_NONE, RNG_NONE,
      RNG_NONE, RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_UNIT, 3'd4), mk_rng(PFX_UNIT, 3'd3), mk_rng(PFX_UNIT, 3'd2),
      mk_rng(PFX_UNIT, 3'd1), mk_rng(PFX_UNIT, 3'd0), RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_UNIT, 3'd2), mk_rng(PFX_KILO, 3'd4), mk_rng(PFX_KILO, 3'd3),
      mk_rng(PFX_KILO, 3'd2), mk_rng(PFX_MEGA, 3'd4), mk_rng(PFX_MEGA, 3'd3),
      mk_rng(PFX_MEGA, 3'd2), RNG_NONE},
    '{mk_rng(PFX_UNIT, 3'd2), RNG_NONE, RNG_NONE, RNG_NONE,
      RNG_NONE, RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_UNIT, 3'd4), RNG_NONE, RNG_NONE, RNG_NONE,
      RNG_NONE, RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_UNIT, 3'd2), mk_rng(PFX_UNIT, 3'd1), RNG_NONE,
      mk_rng(PFX_KILO, 3'd3), mk_rng(PFX_KILO, 3'd2), mk_rng(PFX_MEGA, 3'd4),
      mk_rng(PFX_MEGA, 3'd3), mk_rng(PFX_MEGA, 3'd2)},
    '{mk_rng(PFX_NANO, 3'd3), mk_rng(PFX_NANO, 3'd2), mk_rng(PFX_MICRO, 3'd4),
      mk_rng(PFX_MICRO, 3'd3), mk_rng(PFX_MICRO, 3'd2), mk_rng(PFX_MILLI, 3'd4),
      mk_rng(PFX_MILLI, 3'd3), mk_rng(PFX_MILLI, 3'd2)},
    '{mk_rng(PFX_UNIT, 3'd2), RNG_NONE, RNG_NONE, RNG_NONE,
      RNG_NONE, RNG_NONE, RNG_NONE, RNG_NONE},
    '{mk_rng(PFX_ZERO, 3'd0), mk_rng(PFX_ZERO, 3'd0), mk_rng(PFX_ZERO, 3'd0),
      mk_rng(PFX_ZERO, 3'd0), mk_rng(PFX_ZERO, 3'd0), RNG_NONE, RNG_NONE, RNG_NONE}
  };

  // dial byte to mode and table row, force frequency overrides the dial
  function automatic dial_t dial_lookup(logic [7:0] fn, logic force_freq);
    dial_t d;
    d.hit  = 1'b1;
    d.mode = MODE_FREQ;
    d.row  = DIAL_FREQ;
    if (!force_freq) begin
      case (fn)
        FN_VOLT:     begin d.mode = MODE_VOLT;    d.row = DIAL_VOLT;     end
        FN_AUTO_UA:  begin d.mode = MODE_CURRENT; d.row = DIAL_AUTO_UA;  end
        FN_AUTO_MA:  begin d.mode = MODE_CURRENT; d.row = DIAL_AUTO_MA;  end
        FN_22A:      begin d.mode = MODE_CURRENT; d.row = DIAL_22A;      end
        FN_MANUAL_A: begin d.mode = MODE_CURRENT; d.row = DIAL_MANUAL_A; end
        FN_OHM:      begin d.mode = MODE_OHM;     d.row = DIAL_OHM;      end
        FN_CONT:     begin d.mode = MODE_CONT;    d.row = DIAL_CONT;     end
        FN_DIODE:    begin d.mode = MODE_DIODE;   d.row = DIAL_DIODE;    end
        FN_FREQ:     begin d.mode = MODE_FREQ;    d.row = DIAL_FREQ;     end
        FN_CAP:      begin d.mode = MODE_CAP;     d.row = DIAL_CAP;      end
        FN_TEMP:     begin d.mode = MODE_TEMP;    d.row = DIAL_TEMP;     end
        FN_ADP:      begin d.mode = MODE_ADP;     d.row = DIAL_ADP;      end
        default: begin
          d.hit  = 1'b0;
          d.mode = MODE_UNKNOWN;
          d.row  = DIAL_VOLT;
        end
      endcase
    end
    return d;
  endfunction

  // ascii digit to value, anything else reads as zero
  function automatic logic [3:0] digit_val(logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b inside {[DIGIT_LO:DIGIT_HI]}) begin
      v = b[3:0];
    end
    return v;
  endfunction

endpackage

// ===== rtl/multimeter_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// multimeter_packet_decoder
// decodes one 12-byte multimeter data packet into mode, scale, value and flags
// ----------------------------------------------------------------------------
// One packet request goes in, one decoded result comes out, in order. A
// request is captured in an input register, decoded by table lookups and a
// constant-weight digit sum in combinational logic, and the result is held in
// an output register until taken. out_valid rises when the request moves from
// the input register into the output register; throughput is one packet per
// cycle while the receiver does not stall, limited only by the two
// register stages, which advance together whenever the output register is
// free or being drained. The only state carried between packets is the AC/DC
// coupling, which updates as each packet moves into the output register, so
// it follows acceptance order exactly.

`include "multimeter_packet_decoder_assert.svh"

module multimeter_packet_decoder
  import mpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,

  input  logic     in_valid,
  output logic     in_ready,
  input  mpd_in_t  in_data,

  output logic     out_valid,
  input  logic     out_ready,
  output mpd_out_t out_data
);

  // pipeline control
  logic     in_vld_r;
  mpd_in_t  in_req_r;
  logic     out_vld_r;
  mpd_out_t out_res_r;
  cpl_t     cpl_r;

  logic     adv;        // output register can load this cycle
  logic     in_take;    // request accepted from the input port
  logic     xfer;       // input register moves into output register

  // decode signals
  dial_t      dial;
  range_ent_t rng;
  mode_t      mode_nxt;
  prefix_t    pfx_nxt;
  logic [2:0] point_nxt;
  oper_t      oper_nxt;
  cpl_t       cpl_nxt;
  peak_t      peak_nxt;
  logic [16:0] mag_sum;
  mpd_out_t   res_nxt;

  // handshake: output register frees up when empty or being taken,
  // input register can refill whenever it is empty or moving on
  assign adv      = !out_vld_r || out_ready;
  assign xfer     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;
  assign in_take  = in_valid && in_ready;

  assign out_valid = out_vld_r;
  assign out_data  = out_res_r;

  // decode of the request held in the input register
  always_comb begin
    dial = dial_lookup(in_req_r.function_code, in_req_r.option_three[0]);

    // range lookup; bytes outside the range window, or table holes, give no scale
    rng = RNG_NONE;
    if (dial.hit && (in_req_r.range_code inside {[RANGE_LO:RANGE_HI]})) begin
      rng = RANGE_TBL[dial.row][in_req_r.range_code[RANGE_IDX_W-1:0]];
    end

    mode_nxt  = dial.mode;
    pfx_nxt   = rng.valid ? rng.prefix : PFX_ZERO;
    point_nxt = rng.valid ? rng.point : 3'd0;

    // judge flag turns frequency into duty cycle in percent
    if (dial.mode == MODE_FREQ && in_req_r.status_byte[3]) begin
      mode_nxt  = MODE_DUTY;
      point_nxt = 3'd1;
      pfx_nxt   = PFX_UNIT;
    end

    // temperature point follows the vbar flag
    if (dial.mode == MODE_TEMP) begin
      point_nxt = in_req_r.option_four[2] ? 3'd1 : 3'd2;
      pfx_nxt   = PFX_UNIT;
    end

    // coupling only changes when exactly one of dc and ac is set
    cpl_nxt = cpl_r;
    if (in_req_r.option_three[3] && !in_req_r.option_three[2]) begin
      cpl_nxt = CPL_DC;
    end else if (in_req_r.option_three[2] && !in_req_r.option_three[3]) begin
      cpl_nxt = CPL_AC;
    end

    // underload wins over overload
    if (in_req_r.option_two[3]) begin
      oper_nxt = OP_UNDERLOAD;
    end else if (in_req_r.status_byte[0]) begin
      oper_nxt = OP_OVERLOAD;
    end else begin
      oper_nxt = OP_NORMAL;
    end

    // max wins over min
    if (in_req_r.option_one[3]) begin
      peak_nxt = PEAK_MAX;
    end else if (in_req_r.option_one[2]) begin
      peak_nxt = PEAK_MIN;
    end else begin
      peak_nxt = PEAK_NONE;
    end

    // five ascii digits to binary, constant weights only
    mag_sum = 17'(digit_val(in_req_r.digit_ten_thousands)) * 17'd10000
            + 17'(digit_val(in_req_r.digit_thousands))     * 17'd1000
            + 17'(digit_val(in_req_r.digit_hundreds))      * 17'd100
            + 17'(digit_val(in_req_r.digit_tens))          * 17'd10
            + 17'(digit_val(in_req_r.digit_units));

    res_nxt.mode           = mode_nxt;
    res_nxt.point_position = point_nxt;
    res_nxt.unit_prefix    = pfx_nxt;
    res_nxt.magnitude      = (oper_nxt == OP_NORMAL) ? mag_sum : 17'd0;
    res_nxt.negative       = in_req_r.status_byte[2];
    res_nxt.operation      = oper_nxt;
    res_nxt.coupling       = cpl_nxt;
    res_nxt.auto_range     = in_req_r.option_three[1];
    res_nxt.batt_low       = in_req_r.status_byte[1];
    res_nxt.relative_mode  = in_req_r.option_one[1];
    res_nxt.hold_mode      = in_req_r.option_four[1];
    res_nxt.peak_mode      = peak_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cpl_r     <= CPL_NONE;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      if (xfer) begin
        cpl_r <= cpl_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r <= in_data;
    end
    if (xfer) begin
      out_res_r <= res_nxt;
    end
  end

  // checks
  `MPD_ASSERT_RST(a_reset_empty, !rst_n |=> !in_vld_r && !out_vld_r, "pipeline not empty after reset")
  `MPD_ASSERT(a_mag_zero, out_vld_r && out_res_r.operation != OP_NORMAL |-> out_res_r.magnitude == 17'd0, "magnitude not cleared on overload or underload")
  `MPD_ASSERT(a_cpl_sticky, cpl_r != CPL_NONE |=> cpl_r != CPL_NONE, "coupling fell back to none")
  `MPD_ASSERT(a_duty_scale, out_vld_r && out_res_r.mode == MODE_DUTY |-> out_res_r.point_position == 3'd1 && out_res_r.unit_prefix == PFX_UNIT, "duty cycle scale wrong")

endmodule

// ===== tb/multimeter_packet_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// multimeter_packet_decoder_tb
// self-checking bench for the multimeter packet decoder: a directed sweep of
// every dial byte and the decode corner cases, then random packets, with
// bursty requests, receiver stalls and a per-field compare against an
// in-bench decoder
// ----------------------------------------------------------------------------
module multimeter_packet_decoder_tb;
  import mpd_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  mpd_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mpd_out_t out_data;

  // every dial byte the meter knows, in table order
  localparam logic [7:0] DIAL_CODES [0:11] = '{
    FN_VOLT, FN_AUTO_UA, FN_AUTO_MA, FN_22A, FN_MANUAL_A, FN_OHM,
    FN_CONT, FN_DIODE, FN_FREQ, FN_CAP, FN_TEMP, FN_ADP
  };

  // scale entry {prefix, point}; an empty slot reads as zero multiplier, point 0
  localparam logic [5:0] NO_SCALE = 6'd0;

  // bench-side copy of the only state carried between packets
  cpl_t     held_coupling = CPL_NONE;
  mpd_out_t pending_readings [$];

  int mismatches   = 0;
  int packets_sent = 0;
  int readings_ok  = 0;
  int fault_count  = 0;
  int forced_freq  = 0;
  logic [15:0] modes_seen = '0;

  // sender burst state
  int burst_left = 0;

  multimeter_packet_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // expected decode
  // --------------------------------------------------------------------------

  function automatic logic [5:0] scale(prefix_t p, int unsigned d);
    return {p, 3'(d)};
  endfunction

  // ascii digit, anything outside '0'..'9' counts as zero
  function automatic int unsigned ascii_digit(logic [7:0] b);
    return (b >= DIGIT_LO && b <= DIGIT_HI) ? int'(b - DIGIT_LO) : 0;
  endfunction

  // decodes one packet and advances the held coupling, so it must be called
  // exactly once per accepted request, in acceptance order
  function automatic mpd_out_t predict_reading(mpd_in_t p);
    mpd_out_t    r;
    mode_t       m;
    logic [7:0]  dial;
    logic [5:0]  row [0:7];
    logic [5:0]  sc;
    logic        known;
    int unsigned mag;

    r     = '0;
    m     = MODE_UNKNOWN;
    sc    = NO_SCALE;
    known = 1'b1;
    row   = '{default: NO_SCALE};

    // force frequency wins over whatever the dial says
    dial = p.option_three[0] ? FN_FREQ : p.function_code;
    case (dial)
      FN_VOLT: begin
        m   = MODE_VOLT;
        row = '{scale(PFX_UNIT, 4), scale(PFX_UNIT, 3), scale(PFX_UNIT, 2),
                scale(PFX_UNIT, 1), scale(PFX_MILLI, 2), NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_AUTO_UA: begin
        m   = MODE_CURRENT;
        row = '{scale(PFX_MICRO, 2), scale(PFX_MICRO, 1), NO_SCALE, NO_SCALE,
                NO_SCALE, NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_AUTO_MA: begin
        m   = MODE_CURRENT;
        row = '{scale(PFX_MILLI, 3), scale(PFX_MILLI, 2), NO_SCALE, NO_SCALE,
                NO_SCALE, NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_22A: begin
        m   = MODE_CURRENT;
        row = '{scale(PFX_UNIT, 3), NO_SCALE, NO_SCALE, NO_SCALE,
                NO_SCALE, NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_MANUAL_A: begin
        m   = MODE_CURRENT;
        row = '{scale(PFX_UNIT, 4), scale(PFX_UNIT, 3), scale(PFX_UNIT, 2),
                scale(PFX_UNIT, 1), scale(PFX_UNIT, 0), NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_OHM: begin
        m   = MODE_OHM;
        row = '{scale(PFX_UNIT, 2), scale(PFX_KILO, 4), scale(PFX_KILO, 3),
                scale(PFX_KILO, 2), scale(PFX_MEGA, 4), scale(PFX_MEGA, 3),
                scale(PFX_MEGA, 2), NO_SCALE};
      end
      FN_CONT: begin
        m   = MODE_CONT;
        row = '{scale(PFX_UNIT, 2), NO_SCALE, NO_SCALE, NO_SCALE,
                NO_SCALE, NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_DIODE: begin
        m   = MODE_DIODE;
        row = '{scale(PFX_UNIT, 4), NO_SCALE, NO_SCALE, NO_SCALE,
                NO_SCALE, NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_FREQ: begin
        // third slot is a hole in the frequency table
        m   = MODE_FREQ;
        row = '{scale(PFX_UNIT, 2), scale(PFX_UNIT, 1), NO_SCALE,
                scale(PFX_KILO, 3), scale(PFX_KILO, 2), scale(PFX_MEGA, 4),
                scale(PFX_MEGA, 3), scale(PFX_MEGA, 2)};
      end
      FN_CAP: begin
        m   = MODE_CAP;
        row = '{scale(PFX_NANO, 3), scale(PFX_NANO, 2), scale(PFX_MICRO, 4),
                scale(PFX_MICRO, 3), scale(PFX_MICRO, 2), scale(PFX_MILLI, 4),
                scale(PFX_MILLI, 3), scale(PFX_MILLI, 2)};
      end
      FN_TEMP: begin
        m   = MODE_TEMP;
        row = '{scale(PFX_UNIT, 2), NO_SCALE, NO_SCALE, NO_SCALE,
                NO_SCALE, NO_SCALE, NO_SCALE, NO_SCALE};
      end
      FN_ADP: begin
        // adp ranges are valid but carry a zero multiplier
        m   = MODE_ADP;
        row = '{scale(PFX_ZERO, 0), scale(PFX_ZERO, 0), scale(PFX_ZERO, 0),
                scale(PFX_ZERO, 0), scale(PFX_ZERO, 0), NO_SCALE, NO_SCALE, NO_SCALE};
      end
      default: begin
        known = 1'b0;
      end
    endcase

    if (known && p.range_code >= RANGE_LO && p.range_code <= RANGE_HI) begin
      sc = row[p.range_code[2:0]];
    end
    r.point_position = sc[2:0];
    r.unit_prefix    = sc[5:3];

    // judge turns frequency into duty cycle with a fixed scale
    if (m == MODE_FREQ && p.status_byte[3]) begin
      m                = MODE_DUTY;
      r.point_position = 3'd1;
      r.unit_prefix    = PFX_UNIT;
    end
    // temperature point follows vbar, range byte is ignored
    if (m == MODE_TEMP) begin
      r.point_position = p.option_four[2] ? 3'd1 : 3'd2;
      r.unit_prefix    = PFX_UNIT;
    end
    r.mode = m;

    // coupling only moves when exactly one of dc and ac is set
    if (p.option_three[3] && !p.option_three[2]) begin
      held_coupling = CPL_DC;
    end else if (p.option_three[2] && !p.option_three[3]) begin
      held_coupling = CPL_AC;
    end
    r.coupling = held_coupling;

    // underload takes priority over overload
    if (p.option_two[3]) begin
      r.operation = OP_UNDERLOAD;
    end else if (p.status_byte[0]) begin
      r.operation = OP_OVERLOAD;
    end else begin
      r.operation = OP_NORMAL;
    end

    mag = ascii_digit(p.digit_ten_thousands) * 10000 + ascii_digit(p.digit_thousands) * 1000 +
          ascii_digit(p.digit_hundreds) * 100 + ascii_digit(p.digit_tens) * 10 +
          ascii_digit(p.digit_units);
    r.magnitude = (r.operation == OP_NORMAL) ? mag[16:0] : 17'd0;

    r.negative      = p.status_byte[2];
    r.auto_range    = p.option_three[1];
    r.batt_low      = p.status_byte[1];
    r.relative_mode = p.option_one[1];
    r.hold_mode     = p.option_four[1];
    // max wins over min
    r.peak_mode     = p.option_one[3] ? PEAK_MAX : (p.option_one[2] ? PEAK_MIN : PEAK_NONE);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // every accepted request gets its expected reading queued right away
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_readings.push_back(predict_reading(in_data));
      packets_sent++;
      if (in_data.option_three[0]) begin
        forced_freq++;
      end
    end
  end

  // bursts of random length, random gaps between them; valid stays up
  // with the payload until the request is taken
  task automatic send_packet(input mpd_in_t p);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      // now and then a long burst so the pipe runs back to back
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    burst_left--;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // plain reading "12345" with no flags, on the given dial and range
  function automatic mpd_in_t reading_packet(logic [7:0] fn, logic [7:0] rng);
    mpd_in_t p;
    p                     = '0;
    p.function_code       = fn;
    p.range_code          = rng;
    p.digit_ten_thousands = 8'h31;
    p.digit_thousands     = 8'h32;
    p.digit_hundreds      = 8'h33;
    p.digit_tens          = 8'h34;
    p.digit_units         = 8'h35;
    return p;
  endfunction

  // mostly an ascii digit, sometimes any byte
  function automatic logic [7:0] rand_digit();
    return ($urandom_range(0, 11) != 0) ? DIGIT_LO + 8'($urandom_range(0, 9))
                                         : 8'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // receiver alternates ready stretches and stalls of its own lengths
  initial begin
    int  hold_cycles;
    logic take;
    hold_cycles = 0;
    take        = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles == 0) begin
        take        = ($urandom_range(0, 2) != 0);
        hold_cycles = take ? $urandom_range(1, 24) : $urandom_range(1, 6);
      end
      hold_cycles--;
      out_ready <= take;
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // each result taken is held against the oldest expected reading
  always @(posedge clk) begin
    mpd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("mode",           want.mode,           out_data.mode);
        compare_field("point_position", want.point_position, out_data.point_position);
        compare_field("unit_prefix",    want.unit_prefix,    out_data.unit_prefix);
        compare_field("magnitude",      want.magnitude,      out_data.magnitude);
        compare_field("negative",       want.negative,       out_data.negative);
        compare_field("operation",      want.operation,      out_data.operation);
        compare_field("coupling",       want.coupling,       out_data.coupling);
        compare_field("auto_range",     want.auto_range,     out_data.auto_range);
        compare_field("batt_low",       want.batt_low,       out_data.batt_low);
        compare_field("relative_mode",  want.relative_mode,  out_data.relative_mode);
        compare_field("hold_mode",      want.hold_mode,      out_data.hold_mode);
        compare_field("peak_mode",      want.peak_mode,      out_data.peak_mode);
        readings_ok++;
        if (want.operation != OP_NORMAL) begin
          fault_count++;
        end
        modes_seen[want.mode] = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every dial byte once plus an unknown one; the first packet has neither
  // dc nor ac so the coupling must still read as none after reset
  task automatic test_dial_sweep();
    mpd_in_t p;
    for (int i = 0; i < 12; i++) begin
      p = reading_packet(DIAL_CODES[i], RANGE_LO + 8'(i % 5));
      if (i > 0) begin
        p.option_three = (i % 2) ? 8'h08 : 8'h04;
      end
      send_packet(p);
    end
    // unknown dial byte
    send_packet(reading_packet(8'h00, RANGE_LO));
  endtask

  task automatic test_corner_packets();
    mpd_in_t p;

    // force frequency over the volt dial, top range, dc at the same time
    p = reading_packet(FN_VOLT, RANGE_HI);
    p.option_three = 8'h09;
    send_packet(p);

    // forced frequency with judge becomes duty whatever the range byte
    p = reading_packet(FN_OHM, 8'hFF);
    p.status_byte  = 8'h08;
    p.option_three = 8'h05;
    send_packet(p);

    // frequency table hole, dc and ac together keep the held coupling
    p = reading_packet(FN_FREQ, 8'h32);
    p.option_three = 8'h0C;
    send_packet(p);

    // temperature with vbar, hold, largest reading
    p = reading_packet(FN_TEMP, 8'h35);
    p.option_four         = 8'h06;
    p.digit_ten_thousands = DIGIT_HI;
    p.digit_thousands     = DIGIT_HI;
    p.digit_hundreds      = DIGIT_HI;
    p.digit_tens          = DIGIT_HI;
    p.digit_units         = DIGIT_HI;
    send_packet(p);

    // temperature without vbar, range below the window, all zero digits
    p = reading_packet(FN_TEMP, 8'h2F);
    p.digit_ten_thousands = DIGIT_LO;
    p.digit_thousands     = DIGIT_LO;
    p.digit_hundreds      = DIGIT_LO;
    p.digit_tens          = DIGIT_LO;
    p.digit_units         = DIGIT_LO;
    send_packet(p);

    // range just above the window, digit bytes outside ascii digits
    p = reading_packet(FN_OHM, 8'h38);
    p.digit_ten_thousands = 8'h2F;
    p.digit_thousands     = 8'h3A;
    p.digit_tens          = 8'h80;
    send_packet(p);

    // overload with sign and battery low
    p = reading_packet(FN_CAP, 8'h36);
    p.status_byte = 8'h07;
    send_packet(p);

    // underload and overload together, underload wins
    p = reading_packet(FN_DIODE, RANGE_LO);
    p.status_byte = 8'h01;
    p.option_two  = 8'h08;
    send_packet(p);

    // max and min together with relative, max wins
    p = reading_packet(FN_MANUAL_A, 8'h34);
    p.option_one = 8'h0E;
    send_packet(p);

    // min alone, auto range, neither dc nor ac
    p = reading_packet(FN_AUTO_MA, 8'h31);
    p.option_one   = 8'h04;
    p.option_three = 8'h02;
    send_packet(p);

    // every bit set, then every bit clear
    send_packet('1);
    send_packet('0);
  endtask

  // mostly well-formed packets with random content, some pure noise
  task automatic test_random_packets(input int count);
    mpd_in_t p;
    for (int n = 0; n < count; n++) begin
      p.function_code = ($urandom_range(0, 9) != 0) ? DIAL_CODES[$urandom_range(0, 11)]
                                                    : 8'($urandom);
      p.range_code    = ($urandom_range(0, 6) != 0) ? RANGE_LO + 8'($urandom_range(0, 7))
                                                    : 8'($urandom);
      p.digit_ten_thousands = rand_digit();
      p.digit_thousands     = rand_digit();
      p.digit_hundreds      = rand_digit();
      p.digit_tens          = rand_digit();
      p.digit_units         = rand_digit();
      p.status_byte  = 8'($urandom);
      p.option_one   = 8'($urandom);
      p.option_two   = 8'($urandom);
      p.option_three = 8'($urandom);
      p.option_four  = 8'($urandom);
      // keep faults and forced frequency rare so most magnitudes show up
      if ($urandom_range(0, 4) != 0) begin
        p.status_byte[0] = 1'b0;
      end
      if ($urandom_range(0, 5) != 0) begin
        p.option_two[3] = 1'b0;
      end
      if ($urandom_range(0, 4) != 0) begin
        p.option_three[0] = 1'b0;
      end
      send_packet(p);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_dial_sweep();
    test_corner_packets();
    test_random_packets(500);

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then wait on for anything stray the block might emit
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d of %0d packets, %0d of 11 modes decoded",
             readings_ok, packets_sent, $countones(modes_seen));
    $display("%0d overload or underload packets, %0d with forced frequency",
             fault_count, forced_freq);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d readings outstanding", pending_readings.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
